// ===== rtl/core/fdp_pkg.sv =====
// Shared types and constants for the frame deadline pacer.
`timescale 1ns / 1ps

package fdp_pkg;

  // Field widths
  localparam int RATE_W     = 7;
  localparam int FREQ_W     = 30;
  localparam int NOW_W      = 62;
  localparam int DL_W       = 64;
  localparam int TICKS_W    = 28;
  localparam int UNITS_W    = 21;
  localparam int PROD_W     = 52;   // wait ticks times units per second
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;

  // Pacing limits and scaling
  localparam logic [RATE_W-1:0]  RATE_MIN         = 7'd5;
  localparam logic [RATE_W-1:0]  RATE_MAX         = 7'd120;
  localparam logic [FREQ_W-1:0]  FREQ_RESET       = 30'd10000000;
  localparam logic [PROD_W-1:0]  UNITS_PER_SECOND = 52'd10000000;
  localparam logic [DL_W-1:0]    LATE_PERIODS     = 64'd2;
  localparam logic [TICKS_W-1:0] TICKS_MAX        = '1;
  localparam logic [UNITS_W-1:0] UNITS_MAX        = '1;

  // Step counts of the serial units
  localparam logic [CNT_W-1:0] DIV_STEPS = 6'd52;
  localparam logic [CNT_W-1:0] MUL_STEPS = 6'd28;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_FREQUENCY = 2'd1;

  // Divider status back to the sequencer
  typedef struct packed {
    logic done;   // quotient valid this cycle
    logic ovf;    // quotient did not fit the quotient register
  } div_status_t;

  // Sequencer states
  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_DIVP    = 10'b0000000010,
    ST_LIMIT   = 10'b0000000100,
    ST_CHECK   = 10'b0000001000,
    ST_ADV     = 10'b0000010000,
    ST_REMAIN  = 10'b0000100000,
    ST_MUL     = 10'b0001000000,
    ST_DIVU_GO = 10'b0010000000,
    ST_DIVU    = 10'b0100000000,
    ST_WRITE   = 10'b1000000000
  } state_t;

endpackage

// ===== rtl/core/fdp_in_if.sv =====
// Frame event channel: valid, ready and the tick count.
`timescale 1ns / 1ps

interface fdp_in_if import fdp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NOW_W-1:0] now_ticks;

  modport source (output valid, output now_ticks, input ready);
  modport sink   (input valid, input now_ticks, output ready);
endinterface

// ===== rtl/core/fdp_out_if.sv =====
// Pacing result channel: valid, ready and the wait fields.
`timescale 1ns / 1ps

interface fdp_out_if import fdp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               do_wait;
  logic [TICKS_W-1:0] wait_ticks;
  logic [UNITS_W-1:0] wait_units;

  modport source (output valid, output do_wait, output wait_ticks, output wait_units,
                  input ready);
  modport sink   (input valid, input do_wait, input wait_ticks, input wait_units,
                  output ready);
endinterface

// ===== rtl/core/fdp_cfg_if.sv =====
// Configuration write channel: valid, ready, register index and data.
`timescale 1ns / 1ps

interface fdp_cfg_if import fdp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] value;

  modport source (output valid, output index, output value, input ready);
  modport sink   (input valid, input index, input value, output ready);
endinterface

// ===== rtl/core/fdp_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by period and unit math.
`timescale 1ns / 1ps

module fdp_div import fdp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PROD_W-1:0]  dividend,
  input  logic [FREQ_W-1:0]  divisor,
  output logic [TICKS_W-1:0] quotient,
  output div_status_t        status
);

  logic               running;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]  num;
  logic [FREQ_W-1:0]  den;
  logic [FREQ_W-1:0]  part;
  logic [TICKS_W-1:0] quo;
  logic               ovf;

  logic [FREQ_W:0]    trial;
  logic [FREQ_W:0]    diff;
  logic               fits;

  // One trial subtraction per step
  assign trial = {part, num[PROD_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= DIV_STEPS - 1'b1;
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the dividend in, shift quotient bits out
  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      den  <= divisor;
      part <= '0;
      quo  <= '0;
      ovf  <= 1'b0;
    end else if (running) begin
      num  <= {num[PROD_W-2:0], 1'b0};
      part <= fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
      quo  <= {quo[TICKS_W-2:0], fits};
      ovf  <= ovf | quo[TICKS_W-1];
    end
  end

  assign quotient    = quo;
  assign status.done = done;
  assign status.ovf  = ovf;

endmodule

// ===== rtl/core/frame_deadline_pacer.sv =====
// Frame deadline pacer top level: config, deadline sequencer and result register.
//
//   channel  modport  moves                                   handshake
//   frame    sink     now_ticks                               valid/ready
//   result   source   do_wait, wait_ticks, wait_units         valid/ready
//   cfg      sink     index, value (0 target_rate, 1 freq)    valid/ready, ready tied high
//
// One item at a time. An active item runs through a 52-step period division and its
// done cycle, a limit step, a compare step, up to three advance steps plus a
// leaving step, a 28-step multiply by the units-per-second scale, a start step, a
// 52-step unit division on the shared divider and the write step. An item with rate
// or frequency out of range goes straight to the write step, one with a zero period
// after the period division. Synchronous reset clears config to its defaults and
// the deadline to none. A stalled result waits in the output register; the next
// item is accepted meanwhile and holds in the write step.
`timescale 1ns / 1ps

module frame_deadline_pacer import fdp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fdp_in_if.sink     frame,
  fdp_out_if.source  result,
  fdp_cfg_if.sink    cfg
);

  state_t              state;

  logic [RATE_W-1:0]   target_rate;
  logic [FREQ_W-1:0]   tick_frequency;
  logic [RATE_W-1:0]   last_rate;
  logic [DL_W-1:0]     next_deadline;

  logic [NOW_W-1:0]    now;
  logic [TICKS_W-1:0]  period;
  logic [DL_W-1:0]     work;
  logic [TICKS_W-1:0]  rem_sh;
  logic [PROD_W-1:0]   acc;
  logic [CNT_W-1:0]    cnt;

  logic                res_wait;
  logic [TICKS_W-1:0]  res_ticks;
  logic [UNITS_W-1:0]  res_units;

  logic                out_valid;
  logic                out_wait;
  logic [TICKS_W-1:0]  out_ticks;
  logic [UNITS_W-1:0]  out_units;

  logic                frame_acc;
  logic                enabled;
  logic [DL_W-1:0]     now_ext;
  logic [DL_W-1:0]     diff;

  logic                div_start;
  logic [PROD_W-1:0]   div_dividend;
  logic [FREQ_W-1:0]   div_divisor;
  logic [TICKS_W-1:0]  div_quot;
  div_status_t         div_sts;

  assign frame.ready = (state == ST_IDLE);
  assign frame_acc   = frame.valid && frame.ready;
  assign cfg.ready   = 1'b1;

  assign enabled = (target_rate >= RATE_MIN) && (target_rate <= RATE_MAX) &&
                   (tick_frequency != '0);
  assign now_ext = DL_W'(now);
  assign diff    = next_deadline - now_ext;

  // Divider: period = freq / rate at accept, units = ticks * scale / freq later
  assign div_start    = (frame_acc && enabled) || (state == ST_DIVU_GO);
  assign div_dividend = (state == ST_IDLE) ? PROD_W'(tick_frequency) : acc;
  assign div_divisor  = (state == ST_IDLE) ? FREQ_W'(target_rate) : tick_frequency;

  fdp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .status   (div_sts)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_rate    <= '0;
      tick_frequency <= FREQ_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TARGET_RATE:    target_rate    <= cfg.value[RATE_W-1:0];
        REG_TICK_FREQUENCY: tick_frequency <= cfg.value[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Result valid: set by the write step, cleared when the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_WRITE && (!out_valid || result.ready)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer and deadline state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      last_rate     <= '0;
      next_deadline <= '0;
      cnt           <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (frame_acc) begin
            now <= frame.now_ticks;
            if (enabled) begin
              state <= ST_DIVP;
            end else begin
              res_wait  <= 1'b0;
              res_ticks <= '0;
              res_units <= '0;
              state     <= ST_WRITE;
            end
          end
        end
        ST_DIVP: begin
          if (div_sts.done) begin
            period <= div_quot;
            if (div_quot == '0) begin
              res_wait  <= 1'b0;
              res_ticks <= '0;
              res_units <= '0;
              state     <= ST_WRITE;
            end else begin
              state <= ST_LIMIT;
            end
          end
        end
        ST_LIMIT: begin
          // lateness limit: deadline plus two periods
          work  <= next_deadline + DL_W'(period) * LATE_PERIODS;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (last_rate != target_rate || next_deadline == '0 || now_ext > work) begin
            last_rate     <= target_rate;
            next_deadline <= now_ext + DL_W'(period);
            state         <= ST_REMAIN;
          end else begin
            state <= ST_ADV;
          end
        end
        ST_ADV: begin
          // step past now by whole periods, at most three steps
          if (next_deadline <= now_ext) begin
            next_deadline <= next_deadline + DL_W'(period);
          end else begin
            state <= ST_REMAIN;
          end
        end
        ST_REMAIN: begin
          if (diff[DL_W-1:TICKS_W] != '0) begin
            rem_sh    <= TICKS_MAX;
            res_ticks <= TICKS_MAX;
          end else begin
            rem_sh    <= diff[TICKS_W-1:0];
            res_ticks <= diff[TICKS_W-1:0];
          end
          acc   <= '0;
          cnt   <= MUL_STEPS - 1'b1;
          state <= ST_MUL;
        end
        ST_MUL: begin
          // shift-add, one wait bit per cycle, MSB first
          acc    <= {acc[PROD_W-2:0], 1'b0} +
                    (rem_sh[TICKS_W-1] ? UNITS_PER_SECOND : '0);
          rem_sh <= {rem_sh[TICKS_W-2:0], 1'b0};
          cnt    <= cnt - 1'b1;
          if (cnt == '0) state <= ST_DIVU_GO;
        end
        ST_DIVU_GO: begin
          state <= ST_DIVU;
        end
        ST_DIVU: begin
          if (div_sts.done) begin
            if (div_sts.ovf || div_quot[TICKS_W-1:UNITS_W] != '0) begin
              res_units <= UNITS_MAX;
            end else if (div_quot == '0) begin
              res_units <= UNITS_W'(1);
            end else begin
              res_units <= div_quot[UNITS_W-1:0];
            end
            res_wait <= 1'b1;
            state    <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (!out_valid || result.ready) begin
            out_wait  <= res_wait;
            out_ticks <= res_ticks;
            out_units <= res_units;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid      = out_valid;
  assign result.do_wait    = out_wait;
  assign result.wait_ticks = out_ticks;
  assign result.wait_units = out_units;

`ifndef SYNTHESIS
  // a result without a wait carries zero fields
  a_nowait_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.do_wait |-> result.wait_ticks == '0 && result.wait_units == '0)
    else $error("no-wait result with nonzero wait fields");

  // a waiting result has a positive wait in both units
  a_wait_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.do_wait |-> result.wait_ticks != '0 && result.wait_units != '0)
    else $error("waiting result with zero wait");

  // the deadline only moves while an item is in work
  a_idle_deadline: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |=> $stable(next_deadline))
    else $error("deadline changed while idle");

  // once the wait is computed the deadline lies ahead of now
  a_deadline_ahead: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> next_deadline > now_ext)
    else $error("deadline not ahead of now");

  // divider finishes only where the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> state == ST_DIVP || state == ST_DIVU)
    else $error("divider done outside a division step");
`endif

endmodule

// ===== verif/frame_deadline_pacer_tb.sv =====
// Self-checking testbench for the frame deadline pacer: directed and random frame events.
`timescale 1ns / 1ps

module frame_deadline_pacer_tb;
  import fdp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // idle cycles with no item moving anywhere
  localparam int TAIL_CYCLES    = 300;   // settle time after the last result
  localparam int MAX_REPORTS    = 10;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;
  localparam logic [NOW_W-1:0]     NOW_MAX      = '1;

  // One expected pacing result, tagged with the tick count that caused it
  typedef struct packed {
    logic [NOW_W-1:0]   now_ticks;
    logic               do_wait;
    logic [TICKS_W-1:0] wait_ticks;
    logic [UNITS_W-1:0] wait_units;
  } pace_wait_t;

  logic clk;
  logic rst;

  fdp_in_if  frame_ch ();
  fdp_out_if result_ch ();
  fdp_cfg_if cfg_ch ();

  frame_deadline_pacer dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Mirror of the pacer: configuration and deadline state
  logic [RATE_W-1:0] cfg_rate   = '0;
  logic [FREQ_W-1:0] cfg_freq   = FREQ_RESET;
  logic [RATE_W-1:0] paced_rate = '0;
  logic [DL_W-1:0]   deadline   = '0;

  logic [NOW_W-1:0] pending_frames [$];
  pace_wait_t       expected_waits [$];
  pace_wait_t       oldest_wait;

  int send_idle_pct = 31;
  int recv_idle_pct = 70;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Clock: 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Frame period for the current setting, zero when pacing is off
  function automatic logic [63:0] pace_period();
    if (cfg_rate < RATE_MIN || cfg_rate > RATE_MAX || cfg_freq == '0) return 64'd0;
    return 64'(cfg_freq) / 64'(cfg_rate);
  endfunction

  // Advance the mirrored deadline for one frame event and form its result
  function automatic pace_wait_t pace_frame(input logic [NOW_W-1:0] now_in);
    logic [63:0] now, period, remain, units, missed;
    pace_wait_t  r;
    now         = 64'(now_in);
    r           = '0;
    r.now_ticks = now_in;
    period      = pace_period();
    if (period == 64'd0) return r;
    if (paced_rate != cfg_rate || deadline == '0 ||
        now > deadline + period * LATE_PERIODS) begin
      // rate change, no deadline yet, or too far behind: resync
      paced_rate = cfg_rate;
      deadline   = now + period;
    end else if (deadline <= now) begin
      // skip whole missed periods
      missed   = (now - deadline) / period + 64'd1;
      deadline = deadline + missed * period;
    end
    if (deadline <= now) return r;
    remain = deadline - now;
    if (remain > 64'(TICKS_MAX)) remain = 64'(TICKS_MAX);
    units = remain * 64'(UNITS_PER_SECOND) / 64'(cfg_freq);
    if (units < 64'd1) units = 64'd1;
    if (units > 64'(UNITS_MAX)) units = 64'(UNITS_MAX);
    r.do_wait    = 1'b1;
    r.wait_ticks = remain[TICKS_W-1:0];
    r.wait_units = units[UNITS_W-1:0];
    return r;
  endfunction

  function automatic logic [NOW_W-1:0] random_now();
    return NOW_W'({$urandom, $urandom});
  endfunction

  // Frame driver: feeds pending items, predicts each accepted one
  always @(posedge clk) begin
    if (rst) begin
      frame_ch.valid <= 1'b0;
      paced_rate = '0;
      deadline   = '0;
      cfg_rate   = '0;
      cfg_freq   = FREQ_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_TARGET_RATE:    cfg_rate = cfg_ch.value[RATE_W-1:0];
          REG_TICK_FREQUENCY: cfg_freq = cfg_ch.value[FREQ_W-1:0];
          default: ;
        endcase
      end
      if (frame_ch.valid && frame_ch.ready)
        expected_waits.push_back(pace_frame(frame_ch.now_ticks));
      if (!frame_ch.valid || frame_ch.ready) begin
        if (pending_frames.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          frame_ch.valid     <= 1'b1;
          frame_ch.now_ticks <= pending_frames.pop_front();
        end else begin
          frame_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_waits.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: do_wait=%0d wait_ticks=%0d wait_units=%0d",
                     result_ch.do_wait, result_ch.wait_ticks, result_ch.wait_units);
        end else begin
          oldest_wait = expected_waits.pop_front();
          if (result_ch.do_wait !== oldest_wait.do_wait ||
              result_ch.wait_ticks !== oldest_wait.wait_ticks ||
              result_ch.wait_units !== oldest_wait.wait_units) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"mismatch now=%0d: exp do_wait=%0d wait_ticks=%0d wait_units=%0d,",
                        " got do_wait=%0d wait_ticks=%0d wait_units=%0d"},
                       oldest_wait.now_ticks, oldest_wait.do_wait, oldest_wait.wait_ticks,
                       oldest_wait.wait_units, result_ch.do_wait, result_ch.wait_ticks,
                       result_ch.wait_units);
          end
        end
      end
      result_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Watchdog: too long without any item moving
  always @(posedge clk) begin
    if (rst || (frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_frames.size() != 0 || frame_ch.valid || expected_waits.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.value <= val;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_pacing(input logic [RATE_W-1:0] rate, input logic [FREQ_W-1:0] freq);
    write_reg(REG_TARGET_RATE, CFG_DATA_W'(rate));
    write_reg(REG_TICK_FREQUENCY, freq);
    @(negedge clk);
  endtask

  // Send one frame event and hold off until its result is back
  task automatic send_now(input logic [NOW_W-1:0] t);
    pending_frames.push_back(t);
    wait_drained();
  endtask

  initial begin : stimulus
    logic [63:0] t, per;
    logic [31:0] per32;
    int          kind, n_items, phase, i;

    frame_ch.valid     = 1'b0;
    frame_ch.now_ticks = '0;
    result_ch.ready    = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.value       = '0;
    rst                = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Pacing off at reset rate
    send_now('0);
    send_now(NOW_MAX);

    // Rate write with stray upper bits, writes to unused indexes
    write_reg(REG_TARGET_RATE, 30'h3FFFFF80 | 30'd60);
    write_reg(REG_UNUSED_2, CFG_DATA_W'($urandom));
    write_reg(REG_UNUSED_3, CFG_DATA_W'($urandom));
    @(negedge clk);
    per = pace_period();
    send_now(62'd1000);                         // first deadline
    send_now(62'd1050);                         // early frame
    send_now(deadline[NOW_W-1:0]);              // exactly at deadline
    send_now(NOW_W'(deadline + per + per / 2)); // missed periods
    send_now(NOW_W'(deadline + 2 * per));       // at the lateness limit
    send_now(NOW_W'(deadline + 2 * per + 1));   // just past it: resync
    send_now(62'h100_0000_0000);
    send_now('0);                               // counter backwards: wait saturates
    send_now(NOW_MAX);
    send_now(NOW_MAX);

    // Pacing disabled: rate out of range, zero period, zero frequency
    set_pacing(7'd121, FREQ_RESET);
    send_now(random_now());
    set_pacing(7'd127, FREQ_RESET);
    send_now(random_now());
    set_pacing(7'd4, FREQ_RESET);
    send_now(random_now());
    set_pacing(RATE_MIN, 30'd4);
    send_now(random_now());
    set_pacing(7'd60, 30'd0);
    send_now(random_now());

    // Very low frequency: wait units near and at saturation
    set_pacing(RATE_MIN, 30'd5);
    send_now(62'd100);
    send_now(62'd99);

    // Frequency extremes, wait units floor of one
    set_pacing(RATE_MAX, 30'h3FFFFFFF);
    send_now(random_now());
    set_pacing(RATE_MIN, 30'd1000000000);
    send_now(62'd5000);
    send_now(NOW_W'(deadline - 1));

    // Random phases over a drifting tick timeline
    t = 64'd12345;
    for (phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 70;
        recv_idle_pct = 31;
      end else if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: set_pacing(7'd60, 30'd10000000);
        1: set_pacing(RATE_MIN, 30'd1000000000);
        2: set_pacing(RATE_MAX, 30'h3FFFFFFF);
        3: set_pacing(7'd7, 30'd7);
        4: set_pacing(7'd30, 30'd5000);
        5: set_pacing($urandom_range(1, 0) ? RATE_W'($urandom_range(4, 0))
                                           : RATE_W'($urandom_range(127, 121)),
                      FREQ_W'($urandom));
        7: begin
          // same rate, new frequency: no resync
          write_reg(REG_TICK_FREQUENCY, CFG_DATA_W'($urandom_range(1000000000, 100000)));
          @(negedge clk);
        end
        9: set_pacing(RATE_W'($urandom_range(120, 5)), 30'd0);
        default: set_pacing(RATE_W'($urandom_range(120, 5)),
                            $urandom_range(1, 0) ? FREQ_W'($urandom)
                                                 : FREQ_W'($urandom_range(1000000000, 100000)));
      endcase
      n_items = (phase == 5 || phase == 9) ? 30 : 182;
      per = pace_period();
      if (per == 64'd0) per = 64'd1000;
      per32 = per[31:0];
      for (i = 0; i < n_items; i++) begin
        kind = $urandom_range(99, 0);
        if (kind < 45)      t = t + $urandom_range(per32, 0);                   // early
        else if (kind < 65) t = t + per + $urandom_range(per32 / 4, 0);         // just missed
        else if (kind < 77) t = t + $urandom_range(3 * per32, per32);           // several missed
        else if (kind < 82) t = t + (64'($urandom) << $urandom_range(30, 0));   // long gap
        else if (kind < 87) t = t - $urandom_range(2 * per32, 0);               // small step back
        else if (kind < 91) t = 64'(random_now());
        else if (kind < 95) t = t;                                              // repeated stamp
        else                t = t - (64'($urandom) << 20);                      // far step back
        t = t & 64'(NOW_MAX);
        pending_frames.push_back(t[NOW_W-1:0]);
        if (i == n_items / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_waits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fdp_pkg.sv
rtl/core/fdp_in_if.sv
rtl/core/fdp_out_if.sv
rtl/core/fdp_cfg_if.sv
rtl/core/fdp_div.sv
rtl/core/frame_deadline_pacer.sv
verif/frame_deadline_pacer_tb.sv
